>>> hdl/sha_pkg.sv
// Shared types, constants and round functions of the SHA-256 hash engine.
// Used by sha_front, sha_back, sha_core and sha256_hash_engine; no dependencies.
`default_nettype none

package sha_pkg;

    typedef logic [31:0] word_t;
    typedef logic [15:0][31:0] block_t;
    typedef logic [7:0][31:0] hash_t;

    // One classified input item as it waits in the queue.
    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  nbytes;
        logic        last;
    } item_t;

    // Control from the packer to the compression core.
    typedef struct packed {
        logic start;
        logic init;
    } core_ctrl_t;

    localparam int unsigned QueueDepth = 4;
    localparam logic [2:0] MaxBytes = 3'd4;

    localparam hash_t InitHash = {
        32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
        32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
    };

    function automatic word_t ror32(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Round constants.
    function automatic word_t round_k(input logic [5:0] t);
        word_t k;
        unique case (t)
            6'd0: k = 32'h428A2F98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hB5C0FBCF;  6'd3: k = 32'hE9B5DBA5;
            6'd4: k = 32'h3956C25B;  6'd5: k = 32'h59F111F1;
            6'd6: k = 32'h923F82A4;  6'd7: k = 32'hAB1C5ED5;
            6'd8: k = 32'hD807AA98;  6'd9: k = 32'h12835B01;
            6'd10: k = 32'h243185BE; 6'd11: k = 32'h550C7DC3;
            6'd12: k = 32'h72BE5D74; 6'd13: k = 32'h80DEB1FE;
            6'd14: k = 32'h9BDC06A7; 6'd15: k = 32'hC19BF174;
            6'd16: k = 32'hE49B69C1; 6'd17: k = 32'hEFBE4786;
            6'd18: k = 32'h0FC19DC6; 6'd19: k = 32'h240CA1CC;
            6'd20: k = 32'h2DE92C6F; 6'd21: k = 32'h4A7484AA;
            6'd22: k = 32'h5CB0A9DC; 6'd23: k = 32'h76F988DA;
            6'd24: k = 32'h983E5152; 6'd25: k = 32'hA831C66D;
            6'd26: k = 32'hB00327C8; 6'd27: k = 32'hBF597FC7;
            6'd28: k = 32'hC6E00BF3; 6'd29: k = 32'hD5A79147;
            6'd30: k = 32'h06CA6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27B70A85; 6'd33: k = 32'h2E1B2138;
            6'd34: k = 32'h4D2C6DFC; 6'd35: k = 32'h53380D13;
            6'd36: k = 32'h650A7354; 6'd37: k = 32'h766A0ABB;
            6'd38: k = 32'h81C2C92E; 6'd39: k = 32'h92722C85;
            6'd40: k = 32'hA2BFE8A1; 6'd41: k = 32'hA81A664B;
            6'd42: k = 32'hC24B8B70; 6'd43: k = 32'hC76C51A3;
            6'd44: k = 32'hD192E819; 6'd45: k = 32'hD6990624;
            6'd46: k = 32'hF40E3585; 6'd47: k = 32'h106AA070;
            6'd48: k = 32'h19A4C116; 6'd49: k = 32'h1E376C08;
            6'd50: k = 32'h2748774C; 6'd51: k = 32'h34B0BCB5;
            6'd52: k = 32'h391C0CB3; 6'd53: k = 32'h4ED8AA4A;
            6'd54: k = 32'h5B9CCA4F; 6'd55: k = 32'h682E6FF3;
            6'd56: k = 32'h748F82EE; 6'd57: k = 32'h78A5636F;
            6'd58: k = 32'h84C87814; 6'd59: k = 32'h8CC70208;
            6'd60: k = 32'h90BEFFFA; 6'd61: k = 32'hA4506CEB;
            6'd62: k = 32'hBEF9A3F7; 6'd63: k = 32'hC67178F2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

>>> hdl/sha256_hash_engine.sv
// SHA-256 hash engine, top level: input queue front end and packing/compression back end.
// Depends on sha_pkg, sha_front and sha_back.
//
// Message words enter through a four-item queue; the back end takes one item
// per cycle while it is packing data and the core does not hold back a full
// block, and packs its bytes into 16-word blocks. Each full block runs 64
// rounds in the core, one round per cycle, after the block is loaded and
// before the chaining value is added; packing of the next block goes on while
// the core runs. The last item adds three to eighteen padding and length words,
// which can need a second compression, and then the eight digest words,
// index 0 first, wait on the result side until popped.
`default_nettype none

module sha256_hash_engine
    import sha_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [31:0] data_word,
    input  wire logic [2:0]  valid_bytes,
    input  wire logic        last_item,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);

    logic  q_valid;
    item_t q_item;
    logic  q_pop;

    sha_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_word   (data_word),
        .valid_bytes (valid_bytes),
        .last_item   (last_item),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    sha_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

endmodule

`default_nettype wire

>>> hdl/sha_front.sv
// Front end of the SHA-256 hash engine: classifies input items and queues them.
// Depends on sha_pkg.
`default_nettype none

module sha_front
    import sha_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [31:0] data_word,
    input  wire logic [2:0]  valid_bytes,
    input  wire logic        last_item,
    output logic             q_valid,
    output item_t            q_item,
    input  wire logic        q_pop
);

    localparam int unsigned PtrW = $clog2(QueueDepth);

    item_t            q_reg [QueueDepth];
    logic [PtrW-1:0]  wr_ptr_reg;
    logic [PtrW-1:0]  rd_ptr_reg;
    logic [PtrW:0]    count_reg;
    logic [2:0]       nbytes;
    logic [31:0]      mask;
    logic             do_push;
    logic             do_pop;

    // Clamp the byte count and clear the bytes that are not valid.
    always_comb
    begin
        nbytes = (valid_bytes > MaxBytes) ? MaxBytes : valid_bytes;
        mask   = ~(32'hFFFF_FFFF >> {nbytes, 3'b000});
    end

    assign full    = (count_reg == (PtrW+1)'(QueueDepth));
    assign q_valid = (count_reg != '0);
    assign q_item  = q_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_pop && q_valid;

    // Queue storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= '{data: data_word & mask, nbytes: nbytes, last: last_item};
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/sha_core.sv
// SHA-256 compression core: 64 rounds, one per cycle, with a rolling schedule.
// Depends on sha_pkg.
`default_nettype none

module sha_core
    import sha_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire core_ctrl_t ctrl,
    input  wire block_t     block,
    output logic            busy,
    output hash_t           hash
);

    hash_t      hash_reg;
    hash_t      work_reg;
    block_t     w_reg;
    logic [5:0] rnd_reg;
    logic       busy_reg;
    logic       add_reg;
    word_t      t1;
    word_t      t2;
    word_t      w_new;
    word_t      a, b, c, d, e, f, g, h;

    // One round and one schedule word.
    always_comb
    begin
        a = work_reg[0]; b = work_reg[1]; c = work_reg[2]; d = work_reg[3];
        e = work_reg[4]; f = work_reg[5]; g = work_reg[6]; h = work_reg[7];
        t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
           + round_k(rnd_reg) + w_reg[0];
        t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        w_new = w_reg[0]
              + (ror32(w_reg[1], 7) ^ ror32(w_reg[1], 18) ^ (w_reg[1] >> 3))
              + w_reg[9]
              + (ror32(w_reg[14], 17) ^ ror32(w_reg[14], 19) ^ (w_reg[14] >> 10));
    end

    assign busy = busy_reg;
    assign hash = hash_reg;

    // Round sequencer, working variables and chaining value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= InitHash;
            work_reg <= '0;
            w_reg    <= '0;
            rnd_reg  <= '0;
            busy_reg <= 1'b0;
            add_reg  <= 1'b0;
        end
        else if (ctrl.start)
        begin
            work_reg <= hash_reg;
            w_reg    <= block;
            rnd_reg  <= '0;
            busy_reg <= 1'b1;
        end
        else if (add_reg)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= hash_reg[i] + work_reg[i];
            end
            add_reg  <= 1'b0;
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            work_reg <= {g, f, e, d + t1, c, b, a, t1 + t2};
            w_reg    <= {w_new, w_reg[15:1]};
            rnd_reg  <= rnd_reg + 1'b1;
            add_reg  <= (rnd_reg == 6'd63);
        end
        else if (ctrl.init)
        begin
            hash_reg <= InitHash;
        end
    end

endmodule

`default_nettype wire

>>> hdl/sha_back.sv
// Back end of the SHA-256 hash engine: packs bytes, pads, drives the core, holds the digest.
// Depends on sha_pkg and sha_core.
`default_nettype none

module sha_back
    import sha_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  q_valid,
    input  wire item_t q_item,
    output logic       q_pop,
    output logic       empty,
    input  wire logic  pop,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    typedef enum logic [2:0] {
        ST_DATA, ST_PAD, ST_ZERO, ST_LENHI, ST_LENLO, ST_FIN
    } state_t;

    state_t      state_reg, state_next;
    logic [60:0] cnt_reg, cnt_next, cnt_sum;
    logic [23:0] pend_reg, pend_next;
    logic [63:0] len_reg, len_next;
    block_t      blk_reg;
    block_t      blk_shift;
    hash_t       out_reg;
    logic [2:0]  out_idx_reg;
    logic        out_valid_reg;
    logic        core_busy;
    hash_t       core_hash;
    core_ctrl_t  ctrl;
    logic [3:0]  idx;
    logic [1:0]  pc;
    logic [2:0]  total;
    logic [55:0] comb;
    word_t       pad_word;
    logic        blocked;
    logic        wr_en;
    word_t       wr_word;
    logic        fin;

    sha_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .block (blk_shift),
        .busy  (core_busy),
        .hash  (core_hash)
    );

    // Byte merge of the pending bytes with the new item.
    always_comb
    begin
        idx      = cnt_reg[5:2];
        pc       = cnt_reg[1:0];
        total    = {1'b0, pc} + q_item.nbytes;
        comb     = {pend_reg, 32'h0} | ({q_item.data, 24'h0} >> {pc, 3'b000});
        pad_word = {pend_reg, 8'h00} | (32'h8000_0000 >> {pc, 3'b000});
        blocked  = (idx == 4'd15) && core_busy;
        cnt_sum  = cnt_reg + 61'(q_item.nbytes);
    end

    // Packing and padding sequence.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        len_next   = len_reg;
        wr_en      = 1'b0;
        wr_word    = '0;
        q_pop      = 1'b0;
        fin        = 1'b0;
        unique case (state_reg)
            ST_DATA:
            begin
                if (q_valid && !(total[2] && blocked))
                begin
                    q_pop     = 1'b1;
                    wr_en     = total[2];
                    wr_word   = comb[55:24];
                    pend_next = total[2] ? comb[23:0] : comb[55:32];
                    cnt_next  = cnt_sum;
                    if (q_item.last)
                    begin
                        len_next   = {cnt_sum, 3'b000};
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                if (!blocked)
                begin
                    wr_en      = 1'b1;
                    wr_word    = pad_word;
                    pend_next  = '0;
                    cnt_next   = {cnt_reg[60:2] + 1'b1, 2'b00};
                    state_next = (idx == 4'd13) ? ST_LENHI : ST_ZERO;
                end
            end
            ST_ZERO:
            begin
                if (!blocked)
                begin
                    wr_en      = 1'b1;
                    cnt_next   = cnt_reg + 61'd4;
                    state_next = (idx == 4'd13) ? ST_LENHI : ST_ZERO;
                end
            end
            ST_LENHI:
            begin
                wr_en      = 1'b1;
                wr_word    = len_reg[63:32];
                cnt_next   = cnt_reg + 61'd4;
                state_next = ST_LENLO;
            end
            ST_LENLO:
            begin
                if (!blocked)
                begin
                    wr_en      = 1'b1;
                    wr_word    = len_reg[31:0];
                    cnt_next   = cnt_reg + 61'd4;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!core_busy && !out_valid_reg)
                begin
                    fin        = 1'b1;
                    cnt_next   = '0;
                    pend_next  = '0;
                    state_next = ST_DATA;
                end
            end
            default:
            begin
                state_next = ST_DATA;
            end
        endcase
    end

    // A full block goes to the core as its sixteenth word arrives.
    assign blk_shift = {wr_word, blk_reg[15:1]};
    assign ctrl      = '{start: wr_en && (idx == 4'd15), init: fin};

    assign empty       = !out_valid_reg;
    assign digest_word = out_reg[out_idx_reg];
    assign word_index  = out_idx_reg;
    assign last_word   = (out_idx_reg == 3'd7);

    // Block words and digest words carry no reset.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            blk_reg <= blk_shift;
        end
        if (fin)
        begin
            out_reg <= core_hash;
        end
    end

    // State, counters and output status.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_DATA;
            cnt_reg       <= '0;
            pend_reg      <= '0;
            len_reg       <= '0;
            out_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            len_reg   <= len_next;
            if (fin)
            begin
                out_valid_reg <= 1'b1;
                out_idx_reg   <= '0;
            end
            else if (pop && out_valid_reg)
            begin
                out_idx_reg <= out_idx_reg + 1'b1;
                if (out_idx_reg == 3'd7)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

`ifndef SYNTHESIS
    // The core is never restarted while it still works on a block.
    assert property (@(posedge clk) disable iff (!rst_n) ctrl.start |-> !core_busy)
        else $error("core started while busy");
    // A digest appears only out of the finishing state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("digest shown outside finish");
    // Zero and length words are always word aligned.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ZERO || state_reg == ST_LENHI || state_reg == ST_LENLO)
        |-> cnt_reg[1:0] == 2'b00)
        else $error("padding word misaligned");
    // The low length word always closes a block.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LENLO |-> cnt_reg[5:2] == 4'd15)
        else $error("length word at wrong position");
`endif

endmodule

`default_nettype wire
